FILE: rtl/core/bcf_pkg.sv
`timescale 1ns / 1ps
package bcf_pkg;

    localparam int WORDS_DEFAULT = 64;
    localparam int WORD_BITS     = 32;
    localparam int LEN_W         = 12;
    localparam int IDX_W         = 11;
    localparam int WIDX_W        = 6;
    localparam int POP_W         = 6;
    localparam int POS_W         = 5;
    localparam logic [WORD_BITS-1:0] ALL_ONES = 32'hffff_ffff;

    typedef struct packed {
        logic [LEN_W-1:0] count;
        logic [IDX_W-1:0] first_index;
        logic             first_found;
        logic [IDX_W-1:0] last_index;
        logic             last_found;
    } scan_acc_t;

    // Bits of word w that lie below the used length (bit 31 is the lowest index).
    function automatic logic [WORD_BITS-1:0] word_mask(input logic [31:0] w,
                                                       input logic [LEN_W-1:0] len);
        logic [31:0] start;
        logic [31:0] len32;
        logic [31:0] diff;
        logic [5:0]  amt;
        logic [WORD_BITS-1:0] m;
        start = w << 5;
        len32 = 32'(len);
        diff  = len32 - start;
        amt   = 6'd32 - {1'b0, diff[4:0]};
        if (len32 <= start)
        begin
            m = '0;
        end
        else if (diff >= 32'(WORD_BITS))
        begin
            m = ALL_ONES;
        end
        else
        begin
            m = ALL_ONES << amt;
        end
        return m;
    endfunction

    function automatic logic [POP_W-1:0] pop32(input logic [WORD_BITS-1:0] x);
        logic [POP_W-1:0] n;
        n = '0;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            n = n + POP_W'(x[i]);
        end
        return n;
    endfunction

    // Zeros above the highest set bit; x nonzero.
    function automatic logic [POS_W-1:0] lead_zeros(input logic [WORD_BITS-1:0] x);
        logic [POS_W-1:0] n;
        n = '0;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            if (x[i])
            begin
                n = POS_W'(WORD_BITS - 1 - i);
            end
        end
        return n;
    endfunction

    // Position of the lowest set bit; x nonzero.
    function automatic logic [POS_W-1:0] low_bit(input logic [WORD_BITS-1:0] x);
        logic [POS_W-1:0] n;
        n = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (x[i])
            begin
                n = POS_W'(i);
            end
        end
        return n;
    endfunction

endpackage

FILE: rtl/core/bitmap_count_and_find.sv
`timescale 1ns / 1ps
// Bit vector of WORDS 32-bit words with population count, lowest set index and
// highest clear index. A word write is accepted when start is high and busy is low;
// the vector is then scanned one word per cycle through a single shared scan unit
// fed by the one read port of the word memory; busy stays high until the done strobe.
// Done is high for exactly one cycle with the result on the result ports, and the
// strobe cannot be held off by the receiver. After reset a clearing pass over all
// words runs with busy high. A write of the length register (cfg_valid with
// cfg_ready) while idle starts a masking pass that clears bits beyond the new
// length; busy and a low cfg_ready cover it.
module bitmap_count_and_find #(
    parameter int WORDS = bcf_pkg::WORDS_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [bcf_pkg::WIDX_W-1:0]     word_index,
    input  logic [bcf_pkg::WORD_BITS-1:0]  word_data,
    output logic                           done,
    output logic [bcf_pkg::LEN_W-1:0]      set_count,
    output logic                           all_ones,
    output logic [bcf_pkg::IDX_W-1:0]      first_set_index,
    output logic                           first_set_found,
    output logic [bcf_pkg::IDX_W-1:0]      last_clear_index,
    output logic                           last_clear_found,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bcf_pkg::LEN_W-1:0]      cfg_data
);
    import bcf_pkg::*;

    localparam int AW  = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int CW  = $clog2(WORDS + 1);
    localparam int CAP = WORDS * WORD_BITS;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_MASK,
        S_SCAN
    } state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              pend_reg, pend_next;
    logic [AW-1:0]     pend_addr_reg, pend_addr_next;
    logic [LEN_W-1:0]  length_reg, length_next;
    logic              done_reg, done_next;
    logic [LEN_W-1:0]  set_count_reg, set_count_next;
    logic              all_ones_reg, all_ones_next;
    logic [IDX_W-1:0]  first_index_reg, first_index_next;
    logic              first_found_reg, first_found_next;
    logic [IDX_W-1:0]  last_index_reg, last_index_next;
    logic              last_found_reg, last_found_next;

    logic [LEN_W-1:0]     used_len;
    logic                 accept;
    logic                 cfg_take;
    logic                 in_ok;
    logic                 issue;
    logic                 sweep_end;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic [WORD_BITS-1:0] mem_rdata;
    scan_acc_t            acc;

    assign used_len  = (32'(length_reg) > 32'(CAP)) ? LEN_W'(CAP) : length_reg;
    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = (state_reg == S_CLEAR) || (state_reg == S_IDLE && !start);
    assign cfg_take  = cfg_valid && cfg_ready;
    assign in_ok     = (32'(word_index) < 32'(WORDS))
                    && ((32'(word_index) << 5) < 32'(used_len));
    assign issue     = (state_reg == S_SCAN || state_reg == S_MASK)
                    && (cnt_reg != CW'(WORDS));
    assign sweep_end = (cnt_reg == CW'(WORDS)) && !pend_reg;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = cnt_reg[AW-1:0];
        mem_wdata = '0;
        case (state_reg)
            S_CLEAR:
            begin
                mem_we = 1'b1;
            end
            S_IDLE:
            begin
                mem_we    = accept && in_ok;
                mem_waddr = AW'(word_index);
                mem_wdata = word_data & word_mask(32'(word_index), used_len);
            end
            S_MASK:
            begin
                // read-modify-write, one word behind the read address
                mem_we    = pend_reg;
                mem_waddr = pend_addr_reg;
                mem_wdata = mem_rdata & word_mask(32'(pend_addr_reg), used_len);
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    bcf_mem #(
        .WORDS (WORDS),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (issue),
        .raddr (cnt_reg[AW-1:0]),
        .rdata (mem_rdata)
    );

    bcf_scan_unit #(
        .AW (AW)
    ) u_scan (
        .clk  (clk),
        .clr  (accept),
        .en   (pend_reg && state_reg == S_SCAN),
        .word (mem_rdata),
        .addr (pend_addr_reg),
        .len  (used_len),
        .acc  (acc)
    );

    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        pend_next        = issue;
        pend_addr_next   = issue ? cnt_reg[AW-1:0] : pend_addr_reg;
        length_next      = cfg_take ? cfg_data : length_reg;
        done_next        = 1'b0;
        set_count_next   = set_count_reg;
        all_ones_next    = all_ones_reg;
        first_index_next = first_index_reg;
        first_found_next = first_found_reg;
        last_index_next  = last_index_reg;
        last_found_next  = last_found_reg;
        if (issue)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        case (state_reg)
            S_CLEAR:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(WORDS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                cnt_next = '0;
                if (accept)
                begin
                    state_next = S_SCAN;
                end
                else if (cfg_take)
                begin
                    state_next = S_MASK;
                end
            end
            S_MASK:
            begin
                if (sweep_end)
                begin
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (sweep_end)
                begin
                    state_next       = S_IDLE;
                    done_next        = 1'b1;
                    set_count_next   = acc.count;
                    all_ones_next    = (used_len != '0) && (acc.count == used_len);
                    first_index_next = acc.first_index;
                    first_found_next = acc.first_found;
                    last_index_next  = acc.last_index;
                    last_found_next  = acc.last_found;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            length_reg    <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            length_reg    <= length_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_addr_reg   <= pend_addr_next;
        set_count_reg   <= set_count_next;
        all_ones_reg    <= all_ones_next;
        first_index_reg <= first_index_next;
        first_found_reg <= first_found_next;
        last_index_reg  <= last_index_next;
        last_found_reg  <= last_found_next;
    end

    assign done             = done_reg;
    assign set_count        = set_count_reg;
    assign all_ones         = all_ones_reg;
    assign first_set_index  = first_index_reg;
    assign first_set_found  = first_found_reg;
    assign last_clear_index = last_index_reg;
    assign last_clear_found = last_found_reg;

    a_done_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(state_reg) == S_SCAN && state_reg == S_IDLE))
        else $error("result strobe outside end of scan");

    a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && state_reg == S_SCAN))
        else $error("accepted item did not start a scan");

    a_found_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (first_set_found == (set_count != '0)))
        else $error("first set flag disagrees with count");

    a_full_no_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (done && all_ones) |-> !last_clear_found)
        else $error("full vector reports a clear bit");

    a_no_mem_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> !mem_we)
        else $error("memory written during scan");

endmodule

FILE: rtl/core/bcf_mem.sv
`timescale 1ns / 1ps
module bcf_mem #(
    parameter int WORDS = bcf_pkg::WORDS_DEFAULT,
    parameter int AW    = 6
) (
    input  logic                           clk,
    input  logic                           we,
    input  logic [AW-1:0]                  waddr,
    input  logic [bcf_pkg::WORD_BITS-1:0]  wdata,
    input  logic                           re,
    input  logic [AW-1:0]                  raddr,
    output logic [bcf_pkg::WORD_BITS-1:0]  rdata
);
    import bcf_pkg::*;

    logic [WORD_BITS-1:0] mem_reg [WORDS];
    logic [WORD_BITS-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/bcf_scan_unit.sv
`timescale 1ns / 1ps
module bcf_scan_unit #(
    parameter int AW = 6
) (
    input  logic                           clk,
    input  logic                           clr,
    input  logic                           en,
    input  logic [bcf_pkg::WORD_BITS-1:0]  word,
    input  logic [AW-1:0]                  addr,
    input  logic [bcf_pkg::LEN_W-1:0]      len,
    output bcf_pkg::scan_acc_t             acc
);
    import bcf_pkg::*;

    scan_acc_t            acc_reg;
    scan_acc_t            acc_next;
    logic [WORD_BITS-1:0] clear_bits;
    logic [31:0]          base;
    logic [31:0]          first_cand;
    logic [31:0]          last_cand;

    always_comb
    begin
        clear_bits = ~word & word_mask(32'(addr), len);
        base       = 32'(addr) << 5;
        first_cand = base + 32'(lead_zeros(word));
        last_cand  = base + 32'(5'd31 - low_bit(clear_bits));
        acc_next   = acc_reg;
        if (clr)
        begin
            acc_next = '0;
        end
        else if (en)
        begin
            acc_next.count = acc_reg.count + LEN_W'(pop32(word));
            // words arrive in ascending order: keep the first hit
            if (!acc_reg.first_found && word != '0)
            begin
                acc_next.first_found = 1'b1;
                acc_next.first_index = first_cand[IDX_W-1:0];
            end
            // and the latest clear position
            if (clear_bits != '0)
            begin
                acc_next.last_found = 1'b1;
                acc_next.last_index = last_cand[IDX_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

FILE: dv/bitmap_result_checker.sv
`timescale 1ns / 1ps
module bitmap_result_checker #(
    parameter int WORDS = bcf_pkg::WORDS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic                            busy,
    input  logic [bcf_pkg::WIDX_W-1:0]      word_index,
    input  logic [bcf_pkg::WORD_BITS-1:0]   word_data,
    input  logic                            done,
    input  logic [bcf_pkg::LEN_W-1:0]       set_count,
    input  logic                            all_ones,
    input  logic [bcf_pkg::IDX_W-1:0]       first_set_index,
    input  logic                            first_set_found,
    input  logic [bcf_pkg::IDX_W-1:0]       last_clear_index,
    input  logic                            last_clear_found,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [bcf_pkg::LEN_W-1:0]       cfg_data,
    output int                              errors,
    output int                              pending
);
    import bcf_pkg::*;

    typedef struct packed {
        logic [LEN_W-1:0] set_count;
        logic             all_ones;
        logic [IDX_W-1:0] first_set_index;
        logic             first_set_found;
        logic [IDX_W-1:0] last_clear_index;
        logic             last_clear_found;
    } bitmap_summary_t;

    logic [WORD_BITS-1:0] shadow_words [WORDS];
    logic [LEN_W-1:0]     length_reg;
    bitmap_summary_t      expected_summaries [$];
    bitmap_summary_t      want;

    // Length register saturates at the vector capacity.
    function automatic int bits_in_use(input logic [LEN_W-1:0] len);
        int cap;
        cap = WORDS * WORD_BITS;
        return (int'(len) > cap) ? cap : int'(len);
    endfunction

    // Word bit 31 holds the lowest vector index of the word.
    function automatic logic [WORD_BITS-1:0] live_mask(input int w, input int nbits);
        logic [WORD_BITS-1:0] m;
        m = '0;
        for (int b = 0; b < WORD_BITS; b++)
        begin
            if (w * WORD_BITS + b < nbits)
            begin
                m[WORD_BITS-1-b] = 1'b1;
            end
        end
        return m;
    endfunction

    function automatic bitmap_summary_t summarize_vector();
        bitmap_summary_t s;
        int nbits;
        int count;
        int pos;
        logic bit_val;
        s = '0;
        nbits = bits_in_use(length_reg);
        count = 0;
        for (int w = 0; w < WORDS; w++)
        begin
            for (int b = 0; b < WORD_BITS; b++)
            begin
                pos = w * WORD_BITS + b;
                bit_val = shadow_words[w][WORD_BITS-1-b];
                if (bit_val)
                begin
                    count++;
                    if (!s.first_set_found)
                    begin
                        s.first_set_found = 1'b1;
                        s.first_set_index = IDX_W'(pos);
                    end
                end
                else if (pos < nbits)
                begin
                    s.last_clear_found = 1'b1;
                    s.last_clear_index = IDX_W'(pos);
                end
            end
        end
        s.set_count = LEN_W'(count);
        s.all_ones  = (nbits != 0) && (count == nbits);
        return s;
    endfunction

    task automatic check_field(input string what, input logic [31:0] expv,
                               input logic [31:0] actv);
        if (actv !== expv)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, expv, actv);
            errors = errors + 1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WORDS; i++)
            begin
                shadow_words[i] = '0;
            end
            length_reg = '0;
            expected_summaries.delete();
            errors = 0;
            pending <= 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_summaries.size() == 0)
                begin
                    $display("%0t: result with no item outstanding, expected none actual %0d",
                             $time, set_count);
                    errors = errors + 1;
                end
                else
                begin
                    want = expected_summaries.pop_front();
                    check_field("set_count", 32'(want.set_count), 32'(set_count));
                    check_field("all_ones", 32'(want.all_ones), 32'(all_ones));
                    check_field("first_set_index", 32'(want.first_set_index),
                                32'(first_set_index));
                    check_field("first_set_found", 32'(want.first_set_found),
                                32'(first_set_found));
                    check_field("last_clear_index", 32'(want.last_clear_index),
                                32'(last_clear_index));
                    check_field("last_clear_found", 32'(want.last_clear_found),
                                32'(last_clear_found));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                // new length also clears every stored bit at or past it
                length_reg = cfg_data;
                for (int w = 0; w < WORDS; w++)
                begin
                    shadow_words[w] = shadow_words[w] & live_mask(w, bits_in_use(length_reg));
                end
            end
            if (start && !busy)
            begin
                if (int'(word_index) < WORDS &&
                    int'(word_index) * WORD_BITS < bits_in_use(length_reg))
                begin
                    shadow_words[word_index] = word_data &
                        live_mask(int'(word_index), bits_in_use(length_reg));
                end
                expected_summaries.push_back(summarize_vector());
            end
            pending <= expected_summaries.size();
        end
    end

endmodule

FILE: dv/tb_bitmap_count_and_find.sv
`timescale 1ns / 1ps
module tb_bitmap_count_and_find;
    import bcf_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int PHASES      = 12;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [WIDX_W-1:0]     word_index;
    logic [WORD_BITS-1:0]  word_data;
    logic                  done;
    logic [LEN_W-1:0]      set_count;
    logic                  all_ones;
    logic [IDX_W-1:0]      first_set_index;
    logic                  first_set_found;
    logic [IDX_W-1:0]      last_clear_index;
    logic                  last_clear_found;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [LEN_W-1:0]      cfg_data;

    int errors;
    int pending;
    int cycle_count = 0;
    int items_sent = 0;
    int target;
    int live_words;
    bit no_gaps = 1'b0;
    logic [LEN_W-1:0] phase_len;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    bitmap_count_and_find u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .word_index       (word_index),
        .word_data        (word_data),
        .done             (done),
        .set_count        (set_count),
        .all_ones         (all_ones),
        .first_set_index  (first_set_index),
        .first_set_found  (first_set_found),
        .last_clear_index (last_clear_index),
        .last_clear_found (last_clear_found),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data)
    );

    bitmap_result_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .word_index       (word_index),
        .word_data        (word_data),
        .done             (done),
        .set_count        (set_count),
        .all_ones         (all_ones),
        .first_set_index  (first_set_index),
        .first_set_found  (first_set_found),
        .last_clear_index (last_clear_index),
        .last_clear_found (last_clear_found),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .errors           (errors),
        .pending          (pending)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("bitmap_count_and_find test failed");
            $finish;
        end
    end

    // Holds start until the item is taken; returns at the accepting edge.
    task automatic send_item(input logic [WIDX_W-1:0] idx, input logic [WORD_BITS-1:0] data);
        start      <= 1'b1;
        word_index <= idx;
        word_data  <= data;
        @(negedge clk);
        while (busy)
        begin
            @(negedge clk);
        end
        @(posedge clk);
        items_sent++;
    endtask

    // The gap counts from the point where the block could take the next item.
    task automatic sender_gap();
        int gap;
        if (!no_gaps && $urandom_range(0, 99) < 17)
        begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 80) : $urandom_range(1, 4);
            start <= 1'b0;
            @(negedge clk);
            while (busy)
            begin
                @(negedge clk);
            end
            @(posedge clk);
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic put(input logic [WIDX_W-1:0] idx, input logic [WORD_BITS-1:0] data);
        send_item(idx, data);
        sender_gap();
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(negedge clk);
        while (pending != 0)
        begin
            @(negedge clk);
        end
        @(posedge clk);
    endtask

    task automatic set_length(input logic [LEN_W-1:0] len);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= len;
        @(negedge clk);
        while (!cfg_ready)
        begin
            @(negedge clk);
        end
        @(posedge clk);
        cfg_valid <= 1'b0;
        live_words = ((int'(len) > WORDS_DEFAULT * WORD_BITS ? WORDS_DEFAULT * WORD_BITS
                                                             : int'(len)) + 31) / 32;
    endtask

    function automatic logic [LEN_W-1:0] pick_length();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return LEN_W'(WORDS_DEFAULT * WORD_BITS);
            2: return LEN_W'($urandom_range(WORDS_DEFAULT * WORD_BITS + 1, 4095));
            3: return LEN_W'(32 * $urandom_range(1, WORDS_DEFAULT) - $urandom_range(0, 2));
            default: return LEN_W'($urandom_range(1, WORDS_DEFAULT * WORD_BITS - 1));
        endcase
    endfunction

    task automatic random_item(input int nwords);
        int kind;
        int w;
        logic [WORD_BITS-1:0] d;
        kind = $urandom_range(0, 99);
        if (nwords == 0 || kind < 10)
        begin
            // any index, in range or not
            put(WIDX_W'($urandom_range(0, 63)), $urandom);
        end
        else if ($urandom_range(0, 4 * nwords) == 0)
        begin
            // fill the whole vector, then sometimes knock out one bit
            for (w = 0; w < nwords; w++)
            begin
                put(WIDX_W'(w), '1);
            end
            if ($urandom_range(0, 1) == 1)
            begin
                d = '1;
                d[$urandom_range(0, 31)] = 1'b0;
                put(WIDX_W'($urandom_range(0, nwords - 1)), d);
            end
        end
        else
        begin
            w = $urandom_range(0, nwords - 1);
            case ($urandom_range(0, 5))
                0: d = '1;
                1: d = '0;
                2: d = 32'd1 << $urandom_range(0, 31);
                3:
                begin
                    d = '1;
                    d[$urandom_range(0, 31)] = 1'b0;
                end
                default: d = $urandom;
            endcase
            put(WIDX_W'(w), d);
        end
    endtask

    initial
    begin
        rst_n      <= 1'b0;
        start      <= 1'b0;
        word_index <= '0;
        word_data  <= '0;
        cfg_valid  <= 1'b0;
        cfg_data   <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // length 0 after reset: everything reads empty
        put(6'd0, 32'hffff_ffff);
        put(6'd63, 32'h0000_0001);

        // two words in use, second one just its top bit
        set_length(12'd33);
        put(6'd0, 32'hffff_ffff);
        put(6'd1, 32'hffff_ffff);
        put(6'd1, 32'h0000_0000);
        put(6'd5, 32'haaaa_aaaa);

        // above capacity saturates to the full vector
        set_length(12'd4095);
        put(6'd63, 32'h0000_0001);
        put(6'd0, 32'h8000_0000);
        put(6'd0, 32'h0000_0000);
        put(6'd63, 32'hffff_ffff);
        put(6'd10, 32'hffff_ffff);
        put(6'd42, 32'h5555_5555);

        // shrinking clears the tail of word 10 and all of word 63
        set_length(12'd330);
        put(6'd63, 32'hffff_ffff);
        put(6'd10, 32'hffff_ffff);

        // growing back: the dropped bits stay clear
        set_length(12'd2048);
        put(6'd20, 32'h0000_0000);
        put(6'd63, 32'h0000_0000);

        set_length(12'd1);
        put(6'd0, 32'hffff_ffff);
        put(6'd0, 32'h7fff_ffff);
        put(6'd1, 32'hffff_ffff);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase == 0 || phase == PHASES - 1)
            begin
                phase_len = LEN_W'(WORDS_DEFAULT * WORD_BITS);
            end
            else if (phase == 1)
            begin
                phase_len = 12'd4095;
            end
            else
            begin
                phase_len = pick_length();
            end
            set_length(phase_len);
            no_gaps = (phase == 4);
            target = items_sent + ((live_words == 0) ? 20 : 150);
            while (items_sent < target)
            begin
                random_item(live_words);
                if (phase == 2 && items_sent == target - 75)
                begin
                    drain_results();
                end
            end
        end
        no_gaps = 1'b0;

        drain_results();
        repeat (WORDS_DEFAULT + 8) @(posedge clk);
        if (errors == 0 && pending == 0)
        begin
            $display("bitmap_count_and_find test passed");
        end
        else
        begin
            $display("bitmap_count_and_find test failed");
        end
        $finish;
    end

endmodule
